FILE: design/ipru_pkg.sv
// shared types and constants for the pixel replication upscaler
package ipru_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_FACTOR  = 16;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = COL_W + 1;
    localparam int FACTOR_W    = $clog2(MAX_FACTOR) + 1;
    localparam int COPY_W      = $clog2(MAX_FACTOR);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic       OP_PIXEL  = 1'b0;
    localparam logic       OP_REPLAY = 1'b1;
    localparam logic       REG_SCALE = 1'b0;
    localparam logic       REG_WIDTH = 1'b1;
    localparam logic       ST_OK     = 1'b0;
    localparam logic       ST_ERROR  = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        pixel_t              pixel;
        logic [FACTOR_W-1:0] count;
        logic                row_end;
        logic                status;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic ready;
        cmd_t cmd;
    } cmd_chan_t;

endpackage

FILE: design/ipru_cfg_if.sv
// configuration write channel
interface ipru_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [10:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: design/ipru_in_if.sv
// input item channel
interface ipru_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;

    modport source (output valid, op, blue, green, red, input ready);
    modport sink (input valid, op, blue, green, red, output ready);
endinterface

FILE: design/ipru_out_if.sv
// result channel
interface ipru_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       last_copy;
    logic       row_end;
    logic       status;

    modport source (output valid, out_blue, out_green, out_red, last_copy, row_end, status,
                    input ready);
    modport sink (input valid, out_blue, out_green, out_red, last_copy, row_end, status,
                  output ready);
endinterface

FILE: design/integer_pixel_replication_upscaler.sv
// Integer nearest-neighbour upscaler. Each accepted item gives scale_factor result beats
// (one beat for a rejected item), issued at one beat per cycle from the output register
// while the receiver is ready; the copy counter of the back end counts the beats of an
// item. The accepting edge loads the front stage; the item then moves into the command
// queue and from there into the output register, which holds its first beat. The front
// keeps accepting while up to four commands wait in the queue. Replay items read the line
// store, a 1024 x 24 memory with registered read; it needs no clearing after reset.
// Configuration writes are taken every cycle.
module integer_pixel_replication_upscaler
    import ipru_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ipru_cfg_if.sink   cfg,
    ipru_in_if.sink    pixels,
    ipru_out_if.source copies
);

    cmd_chan_t push_req;
    cmd_chan_t head;
    cmd_t      front_cmd;
    logic      front_valid;
    logic      push_ready;
    logic      pop;

    ipru_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pixels    (pixels),
        .cmd_valid (front_valid),
        .cmd_ready (push_ready),
        .cmd       (front_cmd)
    );

    assign push_req.valid = front_valid;
    assign push_req.ready = push_ready;
    assign push_req.cmd   = front_cmd;

    ipru_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_req   (push_req),
        .push_ready (push_ready),
        .pop_side   (head),
        .pop        (pop)
    );

    ipru_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .copies (copies)
    );

endmodule

FILE: design/ipru_front.sv
// front end: config registers, order check, line store and command build
module ipru_front
    import ipru_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ipru_cfg_if.sink     cfg,
    ipru_in_if.sink      pixels,
    output logic         cmd_valid,
    input  logic         cmd_ready,
    output cmd_t         cmd
);

    logic [FACTOR_W-1:0] scale_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [COL_W-1:0]    column_reg, column_next;
    logic [COPY_W-1:0]   replays_reg, replays_next;

    logic                st_valid_reg, st_valid_next;
    cmd_t                st_cmd_reg, st_cmd_next;
    logic                st_mem_reg, st_mem_next;
    pixel_t              rdata_reg;
    pixel_t              store [MAX_WIDTH];

    logic [FACTOR_W-1:0] eff_f;
    logic [WIDTH_W-1:0]  eff_w;
    logic                accept;
    logic                err;
    logic                ends;
    pixel_t              in_pix;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= FACTOR_W'(1);
            width_reg <= WIDTH_W'(1);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SCALE: scale_reg <= cfg.data[FACTOR_W-1:0];
                REG_WIDTH: width_reg <= cfg.data[WIDTH_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        if (scale_reg == '0)
            eff_f = FACTOR_W'(1);
        else if (scale_reg > FACTOR_W'(MAX_FACTOR))
            eff_f = FACTOR_W'(MAX_FACTOR);
        else
            eff_f = scale_reg;
        if (width_reg == '0)
            eff_w = WIDTH_W'(1);
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
            eff_w = WIDTH_W'(MAX_WIDTH);
        else
            eff_w = width_reg;
    end

    assign pixels.ready = !st_valid_reg || cmd_ready;
    assign accept       = pixels.valid && pixels.ready;
    assign err          = (pixels.op == OP_PIXEL && replays_reg != '0)
                       || (pixels.op == OP_REPLAY && replays_reg == '0);
    assign ends         = ({1'b0, column_reg} + WIDTH_W'(1)) >= eff_w;
    assign in_pix       = '{red: pixels.red, green: pixels.green, blue: pixels.blue};

    always_comb
    begin
        column_next   = column_reg;
        replays_next  = replays_reg;
        st_valid_next = st_valid_reg;
        st_cmd_next   = st_cmd_reg;
        st_mem_next   = st_mem_reg;
        if (st_valid_reg && cmd_ready)
            st_valid_next = 1'b0;
        if (accept)
        begin
            st_valid_next = 1'b1;
            if (err)
            begin
                st_cmd_next = '{pixel: '0, count: FACTOR_W'(1), row_end: 1'b0,
                                status: ST_ERROR};
                st_mem_next = 1'b0;
            end
            else
            begin
                st_cmd_next = '{pixel: in_pix, count: eff_f, row_end: ends, status: ST_OK};
                st_mem_next = (pixels.op == OP_REPLAY);
                if (ends)
                begin
                    column_next = '0;
                    if (pixels.op == OP_PIXEL)
                        replays_next = COPY_W'(eff_f - FACTOR_W'(1));
                    else
                        replays_next = replays_reg - COPY_W'(1);
                end
                else
                    column_next = column_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= '0;
            replays_reg  <= '0;
            st_valid_reg <= 1'b0;
        end
        else
        begin
            column_reg   <= column_next;
            replays_reg  <= replays_next;
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_cmd_reg <= st_cmd_next;
        st_mem_reg <= st_mem_next;
    end

    // line store, one write or one read per accepted item that is not rejected
    always_ff @(posedge clk)
    begin
        if (accept && !err && pixels.op == OP_PIXEL)
            store[column_reg] <= in_pix;
        if (accept && !err && pixels.op == OP_REPLAY)
            rdata_reg <= store[column_reg];
    end

    always_comb
    begin
        cmd = st_cmd_reg;
        if (st_mem_reg)
            cmd.pixel = rdata_reg;
    end

    assign cmd_valid = st_valid_reg;

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        st_valid_reg && st_cmd_reg.status == ST_ERROR |-> st_cmd_reg.count == FACTOR_W'(1)
                                                          && !st_cmd_reg.row_end)
        else $error("error beat must be a single copy");

    a_err_no_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept && err |=> column_reg == $past(column_reg) && replays_reg == $past(replays_reg))
        else $error("rejected item changed row state");

endmodule

FILE: design/ipru_fifo.sv
// short command queue between front and back
module ipru_fifo
    import ipru_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_chan_t push_req,
    output logic      push_ready,
    output cmd_chan_t pop_side,
    input  logic      pop
);

    cmd_t              entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign do_push    = push_req.valid && push_ready;
    assign do_pop     = pop && count_reg != '0;

    assign pop_side.valid = count_reg != '0;
    assign pop_side.ready = pop;
    assign pop_side.cmd   = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_req.cmd;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

FILE: design/ipru_back.sv
// back end: emits the copies of each queued command, one beat per cycle while the receiver is ready
module ipru_back
    import ipru_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_chan_t head,
    output logic      pop,
    ipru_out_if.source copies
);

    logic [COPY_W-1:0] copy_reg;
    logic              out_valid_reg;
    pixel_t            out_pix_reg;
    logic              out_last_reg;
    logic              out_rend_reg;
    logic              out_status_reg;
    logic              emit;
    logic              last;

    assign emit = head.valid && (!out_valid_reg || copies.ready);
    assign last = {1'b0, copy_reg} == (head.cmd.count - FACTOR_W'(1));
    assign pop  = emit && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            copy_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                copy_reg <= last ? '0 : copy_reg + COPY_W'(1);
            if (emit)
                out_valid_reg <= 1'b1;
            else if (copies.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_pix_reg    <= head.cmd.pixel;
            out_last_reg   <= last;
            out_rend_reg   <= last && head.cmd.row_end;
            out_status_reg <= head.cmd.status;
        end
    end

    assign copies.valid     = out_valid_reg;
    assign copies.out_blue  = out_pix_reg.blue;
    assign copies.out_green = out_pix_reg.green;
    assign copies.out_red   = out_pix_reg.red;
    assign copies.last_copy = out_last_reg;
    assign copies.row_end   = out_rend_reg;
    assign copies.status    = out_status_reg;

    a_copy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> {1'b0, copy_reg} < head.cmd.count)
        else $error("copy counter past command count");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == ST_ERROR |-> out_last_reg && !out_rend_reg)
        else $error("error beat not marked as last copy");

endmodule

FILE: verif/tb_top.sv
// testbench for the pixel replication upscaler: directed table, then predicted random rows
module tb_top;
    import ipru_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        pixel_t px;
        logic   last_copy;
        logic   row_end;
        logic   status;
    } beat_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic        op;
        pixel_t      px;
        logic        idx;
        logic [10:0] data;
        logic        typed;
        beat_t       want;
    } dir_row_t;

    localparam int    LIMIT  = 400000;
    localparam int    SETTLE = 8;
    localparam beat_t NO_BEAT     = '0;
    localparam beat_t REJECT_BEAT = '{24'h000000, 1'b1, 1'b0, ST_ERROR};

    localparam int FACTOR_EDGES [5] = '{0, 1, 16, 17, 31};
    localparam int WIDTH_EDGES [4]  = '{0, 1, 1024, 2047};

    localparam dir_row_t DIR_TAB [24] = '{
        '{ROW_ITEM, OP_PIXEL, 24'hff00ff, REG_SCALE, 11'd0, 1'b1, '{24'hff00ff, 1'b1, 1'b1, ST_OK}},
        '{ROW_ITEM, OP_REPLAY, 24'h000000, REG_SCALE, 11'd0, 1'b1, REJECT_BEAT},
        '{ROW_ITEM, OP_PIXEL, 24'h00ff00, REG_SCALE, 11'd0, 1'b1, '{24'h00ff00, 1'b1, 1'b1, ST_OK}},
        '{ROW_CFG, OP_PIXEL, 24'h000000, REG_SCALE, 11'd0, 1'b0, NO_BEAT},
        '{ROW_ITEM, OP_PIXEL, 24'h563412, REG_SCALE, 11'd0, 1'b1, '{24'h563412, 1'b1, 1'b1, ST_OK}},
        '{ROW_CFG, OP_PIXEL, 24'h000000, REG_SCALE, 11'd3, 1'b0, NO_BEAT},
        '{ROW_CFG, OP_PIXEL, 24'h000000, REG_WIDTH, 11'd2047, 1'b0, NO_BEAT},
        '{ROW_ITEM, OP_PIXEL, 24'h030201, REG_SCALE, 11'd0, 1'b0, NO_BEAT},
        '{ROW_ITEM, OP_PIXEL, 24'h204080, REG_SCALE, 11'd0, 1'b0, NO_BEAT},
        '{ROW_ITEM, OP_PIXEL, 24'hdfbf7f, REG_SCALE, 11'd0, 1'b0, NO_BEAT},
        '{ROW_CFG, OP_PIXEL, 24'h000000, REG_WIDTH, 11'd2, 1'b0, NO_BEAT},
        '{ROW_ITEM, OP_PIXEL, 24'h5aaa55, REG_SCALE, 11'd0, 1'b0, NO_BEAT},
        '{ROW_ITEM, OP_PIXEL, 24'h0f0f0f, REG_SCALE, 11'd0, 1'b1, REJECT_BEAT},
        '{ROW_ITEM, OP_REPLAY, 24'h000000, REG_SCALE, 11'd0, 1'b0, NO_BEAT},
        '{ROW_CFG, OP_PIXEL, 24'h000000, REG_SCALE, 11'd17, 1'b0, NO_BEAT},
        '{ROW_ITEM, OP_REPLAY, 24'hffffff, REG_SCALE, 11'd0, 1'b0, NO_BEAT},
        '{ROW_ITEM, OP_REPLAY, 24'h000000, REG_SCALE, 11'd0, 1'b0, NO_BEAT},
        '{ROW_CFG, OP_PIXEL, 24'h000000, REG_SCALE, 11'd31, 1'b0, NO_BEAT},
        '{ROW_ITEM, OP_REPLAY, 24'h000000, REG_SCALE, 11'd0, 1'b0, NO_BEAT},
        '{ROW_ITEM, OP_REPLAY, 24'h000000, REG_SCALE, 11'd0, 1'b1, REJECT_BEAT},
        '{ROW_CFG, OP_PIXEL, 24'h000000, REG_WIDTH, 11'd0, 1'b0, NO_BEAT},
        '{ROW_CFG, OP_PIXEL, 24'h000000, REG_SCALE, 11'd1, 1'b0, NO_BEAT},
        '{ROW_ITEM, OP_PIXEL, 24'h000000, REG_SCALE, 11'd0, 1'b1, '{24'h000000, 1'b1, 1'b1, ST_OK}},
        '{ROW_ITEM, OP_PIXEL, 24'hffffff, REG_SCALE, 11'd0, 1'b1, '{24'hffffff, 1'b1, 1'b1, ST_OK}}
    };

    logic clk;
    logic rst_n;

    ipru_cfg_if cfg_bus ();
    ipru_in_if  in_bus ();
    ipru_out_if out_bus ();

    integer_pixel_replication_upscaler u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .pixels (in_bus),
        .copies (out_bus)
    );

    // predictor state
    pixel_t           line_mem [MAX_WIDTH];
    int               filled_cols;
    logic [COL_W-1:0] col_q;
    logic [3:0]       owed_passes;
    logic [4:0]       factor_reg;
    logic [10:0]      width_reg;

    beat_t copies_due [$];
    beat_t seen_beat;
    beat_t due_beat;
    int    mismatch_count = 0;
    int    cycle_count = 0;
    int    send_idle_pct;
    int    recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int factor_eff(logic [4:0] f);
        if (f == 0)
            return 1;
        if (f > MAX_FACTOR)
            return MAX_FACTOR;
        return int'(f);
    endfunction

    function automatic int width_eff(logic [10:0] w);
        if (w == 0)
            return 1;
        if (w > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(w);
    endfunction

    task automatic predict_copies(logic op, pixel_t px, bit enqueue);
        int     f;
        int     w;
        pixel_t src;
        logic   ends;
        f = factor_eff(factor_reg);
        w = width_eff(width_reg);
        if ((op == OP_PIXEL && owed_passes != 0) || (op == OP_REPLAY && owed_passes == 0))
        begin
            if (enqueue)
                copies_due.push_back(REJECT_BEAT);
            return;
        end
        if (op == OP_PIXEL)
        begin
            line_mem[col_q] = px;
            src = px;
            if (int'(col_q) + 1 > filled_cols)
                filled_cols = int'(col_q) + 1;
        end
        else
            src = line_mem[col_q];
        ends = (int'(col_q) + 1 >= w);
        if (enqueue)
            for (int k = 0; k < f; k++)
                copies_due.push_back('{src, k == f - 1, (k == f - 1) && ends, ST_OK});
        if (ends)
        begin
            col_q = '0;
            if (op == OP_PIXEL)
                owed_passes = 4'(f - 1);
            else
                owed_passes = owed_passes - 4'd1;
        end
        else
            col_q = col_q + COL_W'(1);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 62;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 62;
            end
            default:
            begin
                send_idle_pct  = 34;
                recv_stall_pct = 34;
            end
        endcase
    endtask

    task automatic drain_results();
        in_bus.valid  <= 1'b0;
        cfg_bus.valid <= 1'b0;
        while (copies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [10:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        if (idx == REG_SCALE)
            factor_reg = data[4:0];
        else
            width_reg = data;
    endtask

    task automatic send_pixel(logic op, pixel_t px, bit typed, beat_t want);
        cfg_bus.valid <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.op    <= op;
        in_bus.red   <= px.red;
        in_bus.green <= px.green;
        in_bus.blue  <= px.blue;
        do
            @(posedge clk);
        while (!in_bus.ready);
        predict_copies(op, px, !typed);
        if (typed)
            copies_due.push_back(want);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_bus.ready <= 1'b0;
        else
            out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            seen_beat = {out_bus.out_red, out_bus.out_green, out_bus.out_blue,
                         out_bus.last_copy, out_bus.row_end, out_bus.status};
            if (copies_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: rgb %06h last %0b end %0b st %0b",
                             seen_beat.px, seen_beat.last_copy, seen_beat.row_end,
                             seen_beat.status);
            end
            else
            begin
                due_beat = copies_due.pop_front();
                if (seen_beat != due_beat)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("beat mismatch: want %06h %0b%0b%0b got %06h %0b%0b%0b",
                                 due_beat.px, due_beat.last_copy, due_beat.row_end,
                                 due_beat.status, seen_beat.px, seen_beat.last_copy,
                                 seen_beat.row_end, seen_beat.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int     f_raw;
        int     w_raw;
        int     n_items;
        logic   op;
        pixel_t px;

        rst_n          <= 1'b0;
        cfg_bus.valid  <= 1'b0;
        cfg_bus.index  <= REG_SCALE;
        cfg_bus.data   <= '0;
        in_bus.valid   <= 1'b0;
        in_bus.op      <= OP_PIXEL;
        in_bus.red     <= '0;
        in_bus.green   <= '0;
        in_bus.blue    <= '0;
        filled_cols    = 0;
        col_q          = '0;
        owed_passes    = '0;
        factor_reg     = 5'd1;
        width_reg      = 11'd1;
        set_idling(3);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIR_TAB); i++)
        begin
            if (DIR_TAB[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(DIR_TAB[i].idx, DIR_TAB[i].data);
            end
            else
                send_pixel(DIR_TAB[i].op, DIR_TAB[i].px, DIR_TAB[i].typed, DIR_TAB[i].want);
        end

        for (int p = 0; p < 13; p++)
        begin
            // first phase: start of a full-width row at factor one
            if (p == 0)
            begin
                f_raw   = 1;
                w_raw   = 2047;
                n_items = 60;
            end
            else
            begin
                f_raw   = (p % 3 == 0) ? FACTOR_EDGES[$urandom_range(0, 4)]
                                       : $urandom_range(1, 16);
                w_raw   = (p % 4 == 1) ? WIDTH_EDGES[$urandom_range(0, 3)]
                                       : $urandom_range(1, 6);
                n_items = 32;
            end
            drain_results();
            set_idling(p % 4);
            write_reg(REG_SCALE, 11'(f_raw));
            // replays may only walk over columns already written
            if (owed_passes != 0 && width_eff(11'(w_raw)) > filled_cols)
                w_raw = filled_cols;
            write_reg(REG_WIDTH, 11'(w_raw));
            for (int n = 0; n < n_items; n++)
            begin
                if ($urandom_range(0, 99) < 12)
                    op = 1'($urandom_range(0, 1));
                else
                    op = (owed_passes != 0) ? OP_REPLAY : OP_PIXEL;
                if (op == OP_REPLAY && owed_passes != 0 && int'(col_q) >= filled_cols)
                    op = OP_PIXEL;
                px = 24'($urandom());
                send_pixel(op, px, 1'b0, NO_BEAT);
                if ($urandom_range(0, 49) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && copies_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
design/ipru_pkg.sv
design/ipru_cfg_if.sv
design/ipru_in_if.sv
design/ipru_out_if.sv
design/ipru_front.sv
design/ipru_fifo.sv
design/ipru_back.sv
design/integer_pixel_replication_upscaler.sv
verif/tb_top.sv
